FILE: rtl/core/sorted_bad_block_list_insert_macros.svh
// assertion macros for the sorted bad block list
// no dependencies; included by the module that checks its own logic
`ifndef SORTED_BAD_BLOCK_LIST_INSERT_MACROS_SVH
`define SORTED_BAD_BLOCK_LIST_INSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SBBL_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("sbbl check failed");
`define SBBL_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("sbbl check failed");
`else
`define SBBL_ASSERT_NOW(label, clk, rstn, ante, cons)
`define SBBL_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

FILE: rtl/core/sbbl_pkg.sv
// types and constants for the sorted bad block list
// no dependencies; used by sorted_bad_block_list_insert
`timescale 1ns / 1ps

package sbbl_pkg;

    localparam int DEF_LIST_CAPACITY = 32;
    localparam int DEF_ADDRESS_BITS  = 24;

    localparam int PAGE_W  = 24;
    localparam int INDEX_W = 5;
    localparam int COUNT_W = 6;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_READ   = 1'b1;

    typedef struct packed {
        logic               action;
        logic [PAGE_W-1:0]  page_address;
        logic [INDEX_W-1:0] entry_index;
    } sbbl_in_t;

    typedef struct packed {
        logic [COUNT_W-1:0] entry_count;
        logic               was_present;
        logic               list_full;
        logic [INDEX_W-1:0] position;
        logic [PAGE_W-1:0]  entry_value;
        logic               index_valid;
    } sbbl_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_WAIT,
        ST_SEARCH,
        ST_SHIFT,
        ST_PUT,
        ST_RESULT
    } sbbl_state_t;

endpackage

FILE: rtl/core/sorted_bad_block_list_insert.sv
// sorted bad block list: ascending page address set in a one-port-pair ram
// depends on sbbl_pkg and sorted_bad_block_list_insert_macros.svh
//
//   beat      dir   ports                        payload
//   s_ item   in    s_valid s_ready s_item       sbbl_pkg::sbbl_in_t
//   m_ result out   m_valid m_ready m_result     sbbl_pkg::sbbl_out_t
//
// read: from accept to result register via ram read, format, load
// insert: when the page goes in, search up to the slot, shift the entries from
//   the slot up by one, write, load; a duplicate or a dropped beat stops after
//   the search and loads, and the search may walk the full list
// one beat is in work at a time; the result register lets the next beat in while
//   a result waits; reset clears the count, state and valid only, ram contents are not cleared
`timescale 1ns / 1ps
`include "sorted_bad_block_list_insert_macros.svh"

module sorted_bad_block_list_insert #(
    parameter int LIST_CAPACITY = sbbl_pkg::DEF_LIST_CAPACITY,
    parameter int ADDRESS_BITS  = sbbl_pkg::DEF_ADDRESS_BITS
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  sbbl_pkg::sbbl_in_t  s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output sbbl_pkg::sbbl_out_t m_result
);

    localparam int IDX_W = $clog2(LIST_CAPACITY);
    localparam int CNT_W = $clog2(LIST_CAPACITY + 1);
    localparam int CMP_W = (CNT_W > sbbl_pkg::INDEX_W) ? CNT_W : sbbl_pkg::INDEX_W;
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(LIST_CAPACITY);

    logic [ADDRESS_BITS-1:0] mem [LIST_CAPACITY];
    logic [ADDRESS_BITS-1:0] rd_data_reg;
    logic [IDX_W-1:0]        rd_addr;
    logic                    wr_en;
    logic [IDX_W-1:0]        wr_addr;
    logic [ADDRESS_BITS-1:0] wr_data;

    sbbl_pkg::sbbl_state_t   state_reg, state_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [CNT_W-1:0]        ptr_reg, ptr_next;
    logic [CNT_W-1:0]        slot_reg, slot_next;
    logic [ADDRESS_BITS-1:0] addr_reg, addr_next;
    logic [sbbl_pkg::INDEX_W-1:0] idx_reg, idx_next;
    logic                    idx_ok_reg, idx_ok_next;
    sbbl_pkg::sbbl_out_t     res_reg, res_next;
    sbbl_pkg::sbbl_out_t     out_reg;
    logic                    out_valid_reg;
    logic                    load_out;

    logic [CMP_W-1:0]        idx_ext;
    logic [CMP_W-1:0]        cnt_ext;
    logic                    at_end;
    logic [CNT_W-1:0]        ptr_dec;

    assign idx_ext = CMP_W'(s_item.entry_index);
    assign cnt_ext = CMP_W'(count_reg);
    assign at_end  = (ptr_reg == count_reg);
    assign ptr_dec = ptr_reg - CNT_W'(1);

    // list ram, registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= sbbl_pkg::ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (load_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        ptr_reg    <= ptr_next;
        slot_reg   <= slot_next;
        addr_reg   <= addr_next;
        idx_reg    <= idx_next;
        idx_ok_reg <= idx_ok_next;
        res_reg    <= res_next;
        if (load_out) begin
            out_reg <= res_reg;
        end
    end

    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        ptr_next    = ptr_reg;
        slot_next   = slot_reg;
        addr_next   = addr_reg;
        idx_next    = idx_reg;
        idx_ok_next = idx_ok_reg;
        res_next    = res_reg;
        rd_addr     = ptr_reg[IDX_W-1:0];
        wr_en       = 1'b0;
        wr_addr     = ptr_reg[IDX_W-1:0];
        wr_data     = rd_data_reg;
        load_out    = 1'b0;

        case (state_reg)
            sbbl_pkg::ST_IDLE: begin
                if (s_valid) begin
                    addr_next = ADDRESS_BITS'(s_item.page_address);
                    idx_next  = s_item.entry_index;
                    case (s_item.action)
                        sbbl_pkg::ACT_READ: begin
                            rd_addr     = IDX_W'(s_item.entry_index);
                            idx_ok_next = (idx_ext < cnt_ext);
                            state_next  = sbbl_pkg::ST_RD_WAIT;
                        end
                        sbbl_pkg::ACT_INSERT: begin
                            ptr_next   = '0;
                            rd_addr    = '0;
                            state_next = sbbl_pkg::ST_SEARCH;
                        end
                        default: begin
                            state_next = sbbl_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            sbbl_pkg::ST_RD_WAIT: begin
                res_next             = '0;
                res_next.entry_count = sbbl_pkg::COUNT_W'(count_reg);
                res_next.position    = idx_reg;
                res_next.index_valid = idx_ok_reg;
                res_next.entry_value = idx_ok_reg ? sbbl_pkg::PAGE_W'(rd_data_reg) : '0;
                state_next           = sbbl_pkg::ST_RESULT;
            end
            sbbl_pkg::ST_SEARCH: begin
                res_next             = '0;
                res_next.entry_count = sbbl_pkg::COUNT_W'(count_reg);
                res_next.entry_value = sbbl_pkg::PAGE_W'(addr_reg);
                if (!at_end && (rd_data_reg < addr_reg)) begin
                    ptr_next = ptr_reg + CNT_W'(1);
                    rd_addr  = IDX_W'(ptr_reg + CNT_W'(1));
                end else if (!at_end && (rd_data_reg == addr_reg)) begin
                    res_next.was_present = 1'b1;
                    res_next.position    = sbbl_pkg::INDEX_W'(ptr_reg);
                    state_next           = sbbl_pkg::ST_RESULT;
                end else if (count_reg == CAP_CNT) begin
                    res_next.list_full = 1'b1;
                    state_next         = sbbl_pkg::ST_RESULT;
                end else begin
                    slot_next  = ptr_reg;
                    ptr_next   = count_reg;
                    rd_addr    = IDX_W'(count_reg - CNT_W'(1));
                    state_next = at_end ? sbbl_pkg::ST_PUT : sbbl_pkg::ST_SHIFT;
                end
            end
            sbbl_pkg::ST_SHIFT: begin
                // move entry ptr-1 up to ptr, fetch the one below
                wr_en    = 1'b1;
                wr_addr  = ptr_reg[IDX_W-1:0];
                wr_data  = rd_data_reg;
                ptr_next = ptr_dec;
                rd_addr  = IDX_W'(ptr_reg - CNT_W'(2));
                if (ptr_dec == slot_reg) begin
                    state_next = sbbl_pkg::ST_PUT;
                end
            end
            sbbl_pkg::ST_PUT: begin
                wr_en                = 1'b1;
                wr_addr              = slot_reg[IDX_W-1:0];
                wr_data              = addr_reg;
                count_next           = count_reg + CNT_W'(1);
                res_next             = '0;
                res_next.entry_count = sbbl_pkg::COUNT_W'(count_reg + CNT_W'(1));
                res_next.position    = sbbl_pkg::INDEX_W'(slot_reg);
                res_next.entry_value = sbbl_pkg::PAGE_W'(addr_reg);
                state_next           = sbbl_pkg::ST_RESULT;
            end
            sbbl_pkg::ST_RESULT: begin
                if (!out_valid_reg || m_ready) begin
                    load_out   = 1'b1;
                    state_next = sbbl_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = sbbl_pkg::ST_IDLE;
            end
        endcase
    end

    assign s_ready  = (state_reg == sbbl_pkg::ST_IDLE);
    assign m_valid  = out_valid_reg;
    assign m_result = out_reg;

    `SBBL_ASSERT_NOW(a_count_in_range, aclk, aresetn, 1'b1, count_reg <= CAP_CNT)
    `SBBL_ASSERT_NOW(a_write_only_when_moving, aclk, aresetn, wr_en,
        (state_reg == sbbl_pkg::ST_SHIFT) || (state_reg == sbbl_pkg::ST_PUT))
    `SBBL_ASSERT_NOW(a_shift_above_slot, aclk, aresetn, state_reg == sbbl_pkg::ST_SHIFT,
        (ptr_reg > slot_reg) && (ptr_reg <= count_reg))
    `SBBL_ASSERT_NEXT(a_put_grows_count, aclk, aresetn, state_reg == sbbl_pkg::ST_PUT,
        count_reg == $past(count_reg) + CNT_W'(1))
    `SBBL_ASSERT_NEXT(a_load_raises_valid, aclk, aresetn, load_out,
        m_valid && (state_reg == sbbl_pkg::ST_IDLE))

endmodule
